### rtl/core/peb_pkg.sv
// Shared types and constants of the prioritized entropy byte buffer.
// No dependencies.
package peb_pkg;
  localparam int SegmentDepth = 4096;
  localparam int ChunkLimit   = 1024;
  localparam int LenW  = 13;
  localparam int FillW = 13;

  localparam logic [1:0] StStored   = 2'd0;
  localparam logic [1:0] StOverflow = 2'd1;
  localparam logic [1:0] StError    = 2'd2;
  localparam logic [1:0] StDrain    = 2'd3;

  localparam logic [1:0] RegBackpressure = 2'd0;
  localparam logic [1:0] RegCapacity     = 2'd1;
  localparam logic [1:0] RegDrainEnable  = 2'd2;

  localparam logic OpStore = 1'b0;
  localparam logic OpDrain = 1'b1;

  // one decoded item handed from the front part to the back part
  typedef struct packed {
    logic       opcode;
    logic [1:0] quality;
    logic [LenW-1:0] block_length;
    logic [7:0] data_byte;
  } item_t;

  // input tdata packing, lowest field first, padded to 32 bits
  localparam int InDataW = 32;
  // output tdata packing, padded to 56 bits
  localparam int OutDataW = 56;
endpackage

### rtl/core/peb_front.sv
// Front part: accepts items and holds them in a short queue.
// Depends on peb_pkg.
module peb_front (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_tvalid,
  output logic                  in_tready,
  input  logic [peb_pkg::InDataW-1:0] in_tdata,
  output logic                  q_valid,
  input  logic                  q_ready,
  output peb_pkg::item_t        q_item
);
  import peb_pkg::*;

  item_t      buf_r [2];
  logic       wp_r, wp_nxt, rp_r, rp_nxt;
  logic [1:0] cnt_r, cnt_nxt;
  item_t      in_item;
  logic       push, pop;

  assign in_item.opcode       = in_tdata[0];
  assign in_item.quality      = in_tdata[2:1];
  assign in_item.block_length = in_tdata[15:3];
  assign in_item.data_byte    = in_tdata[23:16];

  assign in_tready = (cnt_r != 2'd2);
  assign q_valid   = (cnt_r != 2'd0);
  assign q_item    = buf_r[rp_r];
  assign push = in_tvalid && in_tready;
  assign pop  = q_valid && q_ready;

  always_comb begin
    wp_nxt  = push ? ~wp_r : wp_r;
    rp_nxt  = pop ? ~rp_r : rp_r;
    cnt_nxt = cnt_r + {1'b0, push} - {1'b0, pop};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= 1'b0;
      rp_r  <= 1'b0;
      cnt_r <= 2'd0;
    end else begin
      wp_r  <= wp_nxt;
      rp_r  <= rp_nxt;
      cnt_r <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) buf_r[wp_r] <= in_item;
  end

  a_cnt_range: assert property (@(posedge clk) disable iff (!rst_n) cnt_r != 2'd3)
    else $error("queue count out of range");
  a_full_stall: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r == 2'd2 |-> !in_tready) else $error("accept while full");
  a_count_track: assert property (@(posedge clk) disable iff (!rst_n)
    push && !pop && cnt_r == 2'd0 |=> cnt_r == 2'd1) else $error("count slip");
endmodule

### rtl/core/peb_back.sv
// Back part: admission, three byte stores, chunked drain, result register.
// Depends on peb_pkg.
module peb_back #(
  parameter int SEG_DEPTH   = peb_pkg::SegmentDepth,
  parameter int CHUNK_LIMIT = peb_pkg::ChunkLimit
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  q_valid,
  output logic                  q_ready,
  input  peb_pkg::item_t        q_item,
  input  logic                  backpressure_enable,
  input  logic [12:0]           cap_limit,
  input  logic                  drain_enable,
  output logic                  out_tvalid,
  input  logic                  out_tready,
  output logic [peb_pkg::OutDataW-1:0] out_tdata
);
  import peb_pkg::*;

  localparam int AW = $clog2(SEG_DEPTH);
  localparam int CW = $clog2(CHUNK_LIMIT + 1);
  localparam int FW = $clog2(SEG_DEPTH + 1);
  localparam int PW = (FW > LenW ? FW : LenW) + 1;

  typedef enum logic [1:0] {S_IDLE, S_READ, S_OUT} state_t;

  logic [7:0] mem0 [SEG_DEPTH];
  logic [7:0] mem1 [SEG_DEPTH];
  logic [7:0] mem2 [SEG_DEPTH];

  state_t state_r;
  logic [AW-1:0] rptr_r [3];
  logic [AW-1:0] wptr_r [3];
  logic [FW-1:0] fill_r [3];
  logic [LenW-1:0] bleft_r;
  logic [1:0] btgt_r;
  logic       bdisc_r;
  logic [CW-1:0] cleft_r;
  logic [1:0] clvl_r;
  logic [7:0] rd0_r, rd1_r, rd2_r;

  logic [1:0] res_status_r, res_slevel_r, res_olevel_r;
  logic       res_valid_r, res_last_r;

  logic [PW-1:0] cap;
  logic [PW-1:0] sum_q, sum_m;
  logic fit_q, fit_m;
  logic [1:0] qm1;
  logic [1:0] q_idx, m_idx;
  logic new_blk, err;
  logic [1:0] tgt;
  logic disc;
  logic do_wr;
  logic [1:0] dlvl;
  logic [CW-1:0] dleft;
  logic dpop;
  logic [7:0] obyte;

  assign cap = ({1'b0, cap_limit} > PW'(SEG_DEPTH)) ? PW'(SEG_DEPTH)
             : PW'(cap_limit);
  assign qm1 = q_item.quality - 2'd1;
  assign q_idx = (q_item.quality == 2'd3) ? 2'd0 : q_item.quality;
  assign m_idx = (q_item.quality == 2'd0 || q_item.quality == 2'd3) ? 2'd0 : qm1;
  assign sum_q = PW'(fill_r[q_idx]) + PW'(q_item.block_length);
  assign sum_m = PW'(fill_r[m_idx]) + PW'(q_item.block_length);
  assign fit_q = sum_q <= cap;
  assign fit_m = sum_m <= cap;

  always_comb begin
    new_blk = (bleft_r == '0);
    err = new_blk && (q_item.block_length == '0 || q_item.quality == 2'd3);
    tgt  = btgt_r;
    disc = bdisc_r;
    if (new_blk && !err) begin
      tgt  = q_item.quality;
      disc = 1'b0;
      if (!fit_q) begin
        if (backpressure_enable && q_item.quality != 2'd0 && fit_m) tgt = qm1;
        else disc = 1'b1;
      end
    end
    do_wr = !err && !disc && (fill_r[tgt] < FW'(SEG_DEPTH));
    // chunk selection for a drain
    dlvl  = clvl_r;
    dleft = cleft_r;
    if (cleft_r == '0) begin
      if (fill_r[2] != '0) begin
        dlvl = 2'd2;
        dleft = (fill_r[2] > FW'(CHUNK_LIMIT)) ? CW'(CHUNK_LIMIT) : CW'(fill_r[2]);
      end else if (fill_r[1] != '0) begin
        dlvl = 2'd1;
        dleft = (fill_r[1] > FW'(CHUNK_LIMIT)) ? CW'(CHUNK_LIMIT) : CW'(fill_r[1]);
      end else if (fill_r[0] != '0) begin
        dlvl = 2'd0;
        dleft = (fill_r[0] > FW'(CHUNK_LIMIT)) ? CW'(CHUNK_LIMIT) : CW'(fill_r[0]);
      end
    end
    dpop = drain_enable && dleft != '0 && dlvl != 2'd3 && fill_r[dlvl] != '0;
    case (res_olevel_r)
      2'd2:    obyte = rd2_r;
      2'd1:    obyte = rd1_r;
      default: obyte = rd0_r;
    endcase
  end

  assign q_ready    = (state_r == S_IDLE);
  assign out_tvalid = (state_r == S_OUT);
  assign out_tdata = {1'b0, FillW'(fill_r[2]), FillW'(fill_r[1]), FillW'(fill_r[0]),
                      res_last_r, res_valid_r ? res_olevel_r : 2'd0,
                      res_valid_r ? obyte : 8'd0, res_valid_r,
                      res_slevel_r, res_status_r};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      for (int i = 0; i < 3; i++) begin
        rptr_r[i] <= '0; wptr_r[i] <= '0; fill_r[i] <= '0;
      end
      bleft_r <= '0; btgt_r <= '0; bdisc_r <= 1'b0;
      cleft_r <= '0; clvl_r <= '0;
      res_status_r <= StStored; res_slevel_r <= '0; res_olevel_r <= '0;
      res_valid_r <= 1'b0; res_last_r <= 1'b0;
    end else begin
      case (state_r)
        S_IDLE: if (q_valid) begin
          state_r <= S_READ;
          res_valid_r <= 1'b0; res_last_r <= 1'b0; res_olevel_r <= '0;
          if (q_item.opcode == OpStore) begin
            if (err) begin
              res_status_r <= StError; res_slevel_r <= '0;
            end else begin
              btgt_r <= tgt; bdisc_r <= disc;
              res_slevel_r <= tgt;
              res_status_r <= disc ? StOverflow : StStored;
              bleft_r <= (new_blk ? q_item.block_length : bleft_r) - 1'b1;
              if (do_wr) begin
                wptr_r[tgt] <= (wptr_r[tgt] == AW'(SEG_DEPTH - 1)) ? '0 : wptr_r[tgt] + 1'b1;
                fill_r[tgt] <= fill_r[tgt] + 1'b1;
              end
            end
          end else begin
            res_status_r <= StDrain; res_slevel_r <= '0;
            if (drain_enable) begin
              clvl_r <= dlvl;
              if (dleft != '0 && !dpop) cleft_r <= '0;
              else cleft_r <= dleft - (dpop ? 1'b1 : 1'b0);
              if (dpop) begin
                res_valid_r <= 1'b1; res_olevel_r <= dlvl;
                res_last_r <= (dleft == CW'(1));
                rptr_r[dlvl] <= (rptr_r[dlvl] == AW'(SEG_DEPTH - 1)) ? '0
                              : rptr_r[dlvl] + 1'b1;
                fill_r[dlvl] <= fill_r[dlvl] - 1'b1;
              end
            end
          end
        end
        S_READ:  state_r <= S_OUT;
        S_OUT:   if (out_tready) state_r <= S_IDLE;
        default: state_r <= S_IDLE;
      endcase
    end
  end

  // stores: write in the admit cycle, read data registered in the cycle after
  always_ff @(posedge clk) begin
    if (state_r == S_IDLE && q_valid && q_item.opcode == OpStore && do_wr) begin
      if (tgt == 2'd2) mem2[wptr_r[2]] <= q_item.data_byte;
      else if (tgt == 2'd1) mem1[wptr_r[1]] <= q_item.data_byte;
      else mem0[wptr_r[0]] <= q_item.data_byte;
    end
  end
  // rptr was advanced at admit; read the entry just popped
  always_ff @(posedge clk) begin
    rd0_r <= mem0[rptr_r[0] - AW'(1) + ((rptr_r[0] == '0) ? AW'(SEG_DEPTH) : AW'(0))];
    rd1_r <= mem1[rptr_r[1] - AW'(1) + ((rptr_r[1] == '0) ? AW'(SEG_DEPTH) : AW'(0))];
    rd2_r <= mem2[rptr_r[2] - AW'(1) + ((rptr_r[2] == '0) ? AW'(SEG_DEPTH) : AW'(0))];
  end

  a_fill0: assert property (@(posedge clk) disable iff (!rst_n)
    fill_r[0] <= FW'(SEG_DEPTH)) else $error("low fill over depth");
  a_chunk: assert property (@(posedge clk) disable iff (!rst_n)
    cleft_r <= CW'(CHUNK_LIMIT)) else $error("chunk over limit");
  a_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && res_last_r |-> res_valid_r) else $error("last without byte");
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid) else $error("result lost");
endmodule

### rtl/core/peb_cfg.sv
// Configuration registers of the buffer.
// Depends on peb_pkg.
module peb_cfg (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [1:0]  cfg_index,
  input  logic [12:0] cfg_data,
  output logic        bp_en,
  output logic [12:0] seg_cap,
  output logic        drn_en
);
  import peb_pkg::*;
  logic bp_r, drn_r;
  logic [12:0] cap_r;
  assign cfg_ready = 1'b1;
  assign bp_en = bp_r;
  assign seg_cap = cap_r;
  assign drn_en = drn_r;
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      bp_r <= 1'b0; cap_r <= 13'd4096; drn_r <= 1'b1;
    end else if (cfg_valid) begin
      case (cfg_index)
        RegBackpressure: bp_r  <= cfg_data[0];
        RegCapacity:     cap_r <= cfg_data;
        RegDrainEnable:  drn_r <= cfg_data[0];
        default: ;
      endcase
    end
  end
endmodule

### rtl/core/priority_entropy_byte_buffer_top.sv
// Top level of the prioritized entropy byte buffer.
// Depends on peb_pkg, peb_front, peb_back, peb_cfg.
//
//  channel | dir | fields (lowest bit first)
//  in_     | in  | opcode, quality, block_length, data_byte
//  out_    | out | status, stored_level, out_valid, out_byte, out_level,
//          |     | chunk_last, low_fill, medium_fill, high_fill
//  cfg_    | in  | index 0 backpressure_enable, 1 usable bytes per level, 2 drain_enable
//
// Each item passes the back part in three steps: admit and store access,
// registered memory read, result hand-off. The front queue holds two items.
// Reset is synchronous, active low; fills and pointers clear, stores do not.
// A stalled result holds the back part; the front queue accepts until full.
module priority_entropy_byte_buffer_top #(
  parameter int SEGMENT_DEPTH = peb_pkg::SegmentDepth,
  parameter int CHUNK_LIMIT   = peb_pkg::ChunkLimit
) (
  input  logic clk,
  input  logic rst_n,
  input  logic in_tvalid,
  output logic in_tready,
  // opcode[0], quality[2:1], block_length[15:3], data_byte[23:16]
  input  logic [peb_pkg::InDataW-1:0] in_tdata,
  output logic out_tvalid,
  input  logic out_tready,
  // status[1:0], stored_level[3:2], out_valid[4], out_byte[12:5],
  // out_level[14:13], chunk_last[15], low_fill[28:16], medium_fill[41:29],
  // high_fill[54:42]
  output logic [peb_pkg::OutDataW-1:0] out_tdata,
  input  logic cfg_valid,
  output logic cfg_ready,
  input  logic [1:0] cfg_index,
  input  logic [12:0] cfg_data
);
  import peb_pkg::*;
  logic q_valid, q_ready;
  item_t q_item;
  logic bp_en, drn_en;
  logic [12:0] seg_cap;

  peb_cfg u_cfg (.clk, .rst_n, .cfg_valid, .cfg_ready, .cfg_index, .cfg_data,
                 .bp_en, .seg_cap, .drn_en);

  peb_front u_front (.clk, .rst_n, .in_tvalid, .in_tready, .in_tdata,
                     .q_valid, .q_ready, .q_item);

  peb_back #(.SEG_DEPTH(SEGMENT_DEPTH), .CHUNK_LIMIT(CHUNK_LIMIT)) u_back (
    .clk, .rst_n, .q_valid, .q_ready, .q_item,
    .backpressure_enable(bp_en), .cap_limit(seg_cap),
    .drain_enable(drn_en), .out_tvalid, .out_tready, .out_tdata);
endmodule
